// File: design/cluster_membership_table_assert.svh
// Assertion macros for the cluster membership table.
// Depends on a clock named i_clk and an active-low reset named i_rst_n in scope.
`ifndef CLUSTER_MEMBERSHIP_TABLE_ASSERT_SVH
`define CLUSTER_MEMBERSHIP_TABLE_ASSERT_SVH

// Checks a property on every clock edge outside reset.
`define CMT_CHECK(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) else $error(msg);

// Checks that a condition implies a consequence in the next cycle.
`define CMT_CHECK_NEXT(lbl, cond, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (cond) |=> (cons)) \
        else $error(msg);

`endif

// File: design/cmt_pkg.sv
// Shared types and codes of the cluster membership table.
// No dependencies.
`default_nettype none
package cmt_pkg;
    localparam int MAX_NODES_DEF = 16;
    localparam int ID_BYTES_DEF  = 16;

    localparam logic [1:0] OP_MERGE  = 2'd0;
    localparam logic [1:0] OP_AGE    = 2'd1;
    localparam logic [1:0] OP_LOOKUP = 2'd2;
    localparam logic [1:0] OP_NOP    = 2'd3;

    localparam logic [1:0] H_ALIVE   = 2'd0;
    localparam logic [1:0] H_SUSPECT = 2'd1;
    localparam logic [1:0] H_DEAD    = 2'd2;

    localparam logic [2:0] MO_UPDATED   = 3'd0;
    localparam logic [2:0] MO_REFRESHED = 3'd1;
    localparam logic [2:0] MO_INSERTED  = 3'd2;
    localparam logic [2:0] MO_DROPPED   = 3'd3;
    localparam logic [2:0] MO_STALE     = 3'd4;

    localparam logic [2:0] REG_SELF_ID_HIGH    = 3'd0;
    localparam logic [2:0] REG_SELF_ID_LOW     = 3'd1;
    localparam logic [2:0] REG_SELF_ADDRESS    = 3'd2;
    localparam logic [2:0] REG_SELF_CLIENT     = 3'd3;
    localparam logic [2:0] REG_SELF_CLUSTER    = 3'd4;
    localparam logic [2:0] REG_SELF_FIRST      = 3'd5;
    localparam logic [2:0] REG_SELF_LIMIT      = 3'd6;
    localparam logic [2:0] REG_TIMEOUT         = 3'd7;

    localparam logic [31:0] TIMEOUT_RESET = 32'd5000;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_DONE
    } t_state;

    typedef struct packed {
        logic [63:0] id_hi;
        logic [63:0] id_lo;
        logic [31:0] address;
        logic [15:0] cli_port;
        logic [15:0] gsp_port;
        logic [31:0] range_first;
        logic [31:0] range_limit;
        logic [31:0] incarnation;
        logic [1:0]  health;
        logic [31:0] seen_ms;
    } t_entry;

    typedef struct packed {
        logic [1:0]  operation;
        logic [63:0] id_hi;
        logic [63:0] id_lo;
        logic [31:0] address;
        logic [15:0] cli_port;
        logic [15:0] gsp_port;
        logic [31:0] range_first;
        logic [31:0] range_limit;
        logic [31:0] incarnation;
        logic [1:0]  health;
        logic [31:0] now;
        logic [31:0] page;
    } t_item;

    typedef struct packed {
        logic [2:0]  outcome;
        logic        found;
        logic [3:0]  index;
        logic [31:0] address;
        logic [15:0] cli_port;
        logic [15:0] gsp_port;
        logic        local_page;
        logic [4:0]  count;
    } t_result;

    typedef struct packed {
        logic [63:0] id_hi;
        logic [63:0] id_lo;
        logic [31:0] address;
        logic [15:0] cli_port;
        logic [15:0] gsp_port;
        logic [31:0] range_first;
        logic [31:0] range_limit;
        logic [31:0] timeout;
    } t_cfg;

    typedef struct packed {
        logic        we;
        logic [2:0]  index;
        logic [63:0] data;
    } t_cfg_wr;
endpackage
`default_nettype wire

// File: design/cluster_membership_table.sv
// Cluster membership table: merge, age tick and owner lookup over up to MAX_NODES entries.
// A new request is accepted only while idle, after the previous result has been handed off.
// The entry scan reads one memory word a cycle.
// Synchronous active-low reset: entry count 1, entry 0 cleared with incarnation 1, alive;
// self register writes load entry 0. Timeout 5000 ms. No clearing pass is needed.
`default_nettype none
module cluster_membership_table #(
    parameter int MAX_NODES = cmt_pkg::MAX_NODES_DEF,
    parameter int ID_BYTES  = cmt_pkg::ID_BYTES_DEF
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_cfg_we,
    input  wire logic [2:0]  i_cfg_index,
    input  wire logic [63:0] i_cfg_data,
    input  wire logic        i_in_valid,
    output logic             o_in_stall,
    input  wire logic [1:0]  i_operation,
    input  wire logic [63:0] i_node_id_high,
    input  wire logic [63:0] i_node_id_low,
    input  wire logic [31:0] i_node_address,
    input  wire logic [15:0] i_node_client_port,
    input  wire logic [15:0] i_node_cluster_port,
    input  wire logic [31:0] i_node_range_first,
    input  wire logic [31:0] i_node_range_limit,
    input  wire logic [31:0] i_node_incarnation,
    input  wire logic [1:0]  i_node_health,
    input  wire logic [31:0] i_current_ms,
    input  wire logic [31:0] i_page_number,
    output logic             o_out_valid,
    input  wire logic        i_out_stall,
    output logic [2:0]       o_merge_outcome,
    output logic             o_owner_found,
    output logic [3:0]       o_owner_index,
    output logic [31:0]      o_owner_address,
    output logic [15:0]      o_owner_client_port,
    output logic [15:0]      o_owner_cluster_port,
    output logic             o_page_is_local,
    output logic [4:0]       o_member_count
);
    import cmt_pkg::*;

    t_cfg_wr cfg_wr;
    t_cfg    cfg;
    t_item   item;
    t_result res;

    assign cfg_wr.we    = i_cfg_we;
    assign cfg_wr.index = i_cfg_index;
    assign cfg_wr.data  = i_cfg_data;

    assign item.operation    = i_operation;
    assign item.id_hi        = i_node_id_high;
    assign item.id_lo        = i_node_id_low;
    assign item.address      = i_node_address;
    assign item.cli_port     = i_node_client_port;
    assign item.gsp_port     = i_node_cluster_port;
    assign item.range_first  = i_node_range_first;
    assign item.range_limit  = i_node_range_limit;
    assign item.incarnation  = i_node_incarnation;
    assign item.health       = i_node_health;
    assign item.now          = i_current_ms;
    assign item.page         = i_page_number;

    cmt_cfg u_cfg (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_wr   (cfg_wr),
        .o_cfg  (cfg)
    );

    cmt_seq #(.MAX_NODES(MAX_NODES), .ID_BYTES(ID_BYTES)) u_seq (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg      (cfg),
        .i_wr       (cfg_wr),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_item     (item),
        .o_out_valid(o_out_valid),
        .i_out_stall(i_out_stall),
        .o_result   (res)
    );

    assign o_merge_outcome      = res.outcome;
    assign o_owner_found        = res.found;
    assign o_owner_index        = res.index;
    assign o_owner_address      = res.address;
    assign o_owner_client_port  = res.cli_port;
    assign o_owner_cluster_port = res.gsp_port;
    assign o_page_is_local      = res.local_page;
    assign o_member_count       = res.count;
endmodule
`default_nettype wire

// File: design/cmt_mem.sv
// Entry store of the membership table: one write port, one registered read port.
// Depends on cmt_pkg for the entry type.
`default_nettype none
module cmt_mem #(
    parameter int DEPTH = cmt_pkg::MAX_NODES_DEF,
    parameter int IW    = $clog2(cmt_pkg::MAX_NODES_DEF)
) (
    input  wire logic            i_clk,
    input  wire logic            i_we,
    input  wire logic [IW-1:0]   i_waddr,
    input  wire cmt_pkg::t_entry i_wdata,
    input  wire logic [IW-1:0]   i_raddr,
    output cmt_pkg::t_entry      o_rdata
);
    import cmt_pkg::*;

    t_entry r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule
`default_nettype wire

// File: design/cmt_cfg.sv
// Configuration registers of the membership table.
// Depends on cmt_pkg for the register codes and the configuration struct.
`default_nettype none
module cmt_cfg (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire cmt_pkg::t_cfg_wr i_wr,
    output cmt_pkg::t_cfg         o_cfg
);
    import cmt_pkg::*;

    t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg         <= '0;
            r_cfg.timeout <= TIMEOUT_RESET;
        end else if (i_wr.we) begin
            case (i_wr.index)
                REG_SELF_ID_HIGH: r_cfg.id_hi        <= i_wr.data;
                REG_SELF_ID_LOW:  r_cfg.id_lo        <= i_wr.data;
                REG_SELF_ADDRESS: r_cfg.address      <= i_wr.data[31:0];
                REG_SELF_CLIENT:  r_cfg.cli_port     <= i_wr.data[15:0];
                REG_SELF_CLUSTER: r_cfg.gsp_port     <= i_wr.data[15:0];
                REG_SELF_FIRST:   r_cfg.range_first  <= i_wr.data[31:0];
                REG_SELF_LIMIT:   r_cfg.range_limit  <= i_wr.data[31:0];
                REG_TIMEOUT:      r_cfg.timeout      <= i_wr.data[31:0];
                default: ;
            endcase
        end
    end

    assign o_cfg = r_cfg;
endmodule
`default_nettype wire

// File: design/cmt_seq.sv
// Sequencer of the membership table: scans entries, modifies and writes them back.
// Depends on cmt_pkg, cmt_mem and the assertion macro header.
`default_nettype none
`include "cluster_membership_table_assert.svh"
module cmt_seq #(
    parameter int MAX_NODES = cmt_pkg::MAX_NODES_DEF,
    parameter int ID_BYTES  = cmt_pkg::ID_BYTES_DEF
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire cmt_pkg::t_cfg    i_cfg,
    input  wire cmt_pkg::t_cfg_wr i_wr,
    input  wire logic             i_in_valid,
    output logic                  o_in_stall,
    input  wire cmt_pkg::t_item   i_item,
    output logic                  o_out_valid,
    input  wire logic             i_out_stall,
    output cmt_pkg::t_result      o_result
);
    import cmt_pkg::*;

    localparam int IW = $clog2(MAX_NODES);
    localparam int CW = $clog2(MAX_NODES + 1);
    localparam logic [63:0] ID_MASK = ~64'd0 << (8 * (16 - ID_BYTES));
    localparam logic [CW-1:0] MAX_CNT = CW'(MAX_NODES);

    t_state        r_state, n_state;
    t_item         r_in;
    logic [CW-1:0] r_addr, n_addr;
    logic          r_ev_vld, n_ev_vld;
    logic [IW-1:0] r_ev_idx, n_ev_idx;
    logic [CW-1:0] r_total, n_total;
    t_entry        r_e0, n_e0;
    t_result       r_res, n_res;
    t_result       r_out;
    logic          r_out_vld;

    t_entry        mem_rdata;
    t_entry        ent;
    t_entry        mod;
    t_entry        fresh;
    logic          mem_we;
    logic [IW-1:0] mem_waddr;
    logic          issue, finish, id_hit, in_range, out_free, accept;
    logic [31:0]   elapsed;
    logic [1:0]    in_health;

    cmt_mem #(.DEPTH(MAX_NODES), .IW(IW)) u_mem (
        .i_clk  (i_clk),
        .i_we   (mem_we),
        .i_waddr(mem_waddr),
        .i_wdata(mod),
        .i_raddr(r_addr[IW-1:0]),
        .o_rdata(mem_rdata)
    );

    assign accept   = i_in_valid && (r_state == S_IDLE);
    assign out_free = !r_out_vld || !i_out_stall;
    assign issue    = r_addr < r_total;

    always_comb begin
        in_health = (r_in.health > H_DEAD) ? H_DEAD : r_in.health;
        ent       = (r_ev_idx == '0) ? r_e0 : mem_rdata;
        id_hit    = (ent.id_hi == r_in.id_hi) && (((ent.id_lo ^ r_in.id_lo) & ID_MASK) == '0);
        elapsed   = r_in.now - ent.seen_ms;
        in_range  = (ent.health != H_DEAD) && (r_in.page >= ent.range_first)
                    && (r_in.page < ent.range_limit);
        fresh.id_hi        = r_in.id_hi;
        fresh.id_lo        = r_in.id_lo;
        fresh.address      = r_in.address;
        fresh.cli_port     = r_in.cli_port;
        fresh.gsp_port     = r_in.gsp_port;
        fresh.range_first  = r_in.range_first;
        fresh.range_limit  = r_in.range_limit;
        fresh.incarnation  = r_in.incarnation;
        fresh.health       = in_health;
        fresh.seen_ms      = r_in.now;
    end

    // Next state.
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: if (accept) n_state = S_SCAN;
            S_SCAN: if (finish) n_state = S_DONE;
            S_DONE: if (out_free) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    // Datapath and outputs.
    always_comb begin
        n_addr    = r_addr;
        n_ev_vld  = 1'b0;
        n_ev_idx  = r_ev_idx;
        n_total   = r_total;
        n_e0      = r_e0;
        n_res     = r_res;
        mod       = ent;
        mem_we    = 1'b0;
        mem_waddr = r_ev_idx;
        finish    = 1'b0;
        if (accept) begin
            n_addr = '0;
        end
        if (r_state == S_SCAN) begin
            n_res       = '0;
            n_res.local_page = 1'b0;
            if (issue) begin
                n_addr   = r_addr + 1'b1;
                n_ev_vld = 1'b1;
                n_ev_idx = r_addr[IW-1:0];
            end
            case (r_in.operation)
                OP_MERGE: begin
                    if (r_ev_vld && id_hit) begin
                        finish = 1'b1;
                        if (r_in.incarnation > ent.incarnation) begin
                            mod           = fresh;
                            mem_we        = 1'b1;
                            n_res.outcome = MO_UPDATED;
                        end else if (r_in.incarnation == ent.incarnation) begin
                            mod.seen_ms = r_in.now;
                            if (in_health == H_ALIVE) begin
                                mod.health = H_ALIVE;
                            end
                            mem_we        = 1'b1;
                            n_res.outcome = MO_REFRESHED;
                        end else begin
                            n_res.outcome = MO_STALE;
                        end
                    end else if (!r_ev_vld && !issue) begin
                        finish = 1'b1;
                        if (r_total < MAX_CNT) begin
                            mod           = fresh;
                            mem_we        = 1'b1;
                            mem_waddr     = r_total[IW-1:0];
                            n_total       = r_total + 1'b1;
                            n_res.outcome = MO_INSERTED;
                        end else begin
                            n_res.outcome = MO_DROPPED;
                        end
                    end
                end
                OP_AGE: begin
                    if (r_ev_vld && (r_ev_idx != '0)) begin
                        if (ent.health == H_ALIVE && elapsed > (i_cfg.timeout >> 1)) begin
                            mod.health = H_SUSPECT;
                        end else if (ent.health == H_SUSPECT && elapsed > i_cfg.timeout) begin
                            mod.health = H_DEAD;
                        end
                        mem_we = 1'b1;
                    end
                    finish = !r_ev_vld && !issue;
                end
                OP_LOOKUP: begin
                    n_res.local_page = (r_in.page >= i_cfg.range_first)
                                       && (r_in.page < i_cfg.range_limit);
                    if (r_ev_vld && in_range) begin
                        finish             = 1'b1;
                        n_res.found        = 1'b1;
                        n_res.index        = 4'(r_ev_idx);
                        n_res.address      = ent.address;
                        n_res.cli_port     = ent.cli_port;
                        n_res.gsp_port     = ent.gsp_port;
                    end else if (!r_ev_vld && !issue) begin
                        finish = 1'b1;
                    end
                end
                default: finish = 1'b1;
            endcase
            n_res.count = 5'(n_total);
            // Entry zero lives in registers; the memory slot is never written and its read data is ignored.
            if (mem_we && (mem_waddr == '0)) begin
                n_e0   = mod;
                mem_we = 1'b0;
            end
        end
        if (i_wr.we) begin
            case (i_wr.index)
                REG_SELF_ID_HIGH: n_e0.id_hi        = i_wr.data;
                REG_SELF_ID_LOW:  n_e0.id_lo        = i_wr.data;
                REG_SELF_ADDRESS: n_e0.address      = i_wr.data[31:0];
                REG_SELF_CLIENT:  n_e0.cli_port     = i_wr.data[15:0];
                REG_SELF_CLUSTER: n_e0.gsp_port     = i_wr.data[15:0];
                REG_SELF_FIRST:   n_e0.range_first  = i_wr.data[31:0];
                REG_SELF_LIMIT:   n_e0.range_limit  = i_wr.data[31:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_ev_vld    <= 1'b0;
            r_total     <= CW'(1);
            r_out_vld   <= 1'b0;
            r_e0        <= '0;
            r_e0.incarnation <= 32'd1;
            r_e0.health <= H_ALIVE;
        end else begin
            r_state  <= n_state;
            r_ev_vld <= n_ev_vld;
            r_total  <= n_total;
            r_e0     <= n_e0;
            if (r_state == S_DONE && out_free) begin
                r_out_vld <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_addr   <= n_addr;
        r_ev_idx <= n_ev_idx;
        r_res    <= n_res;
        if (accept) begin
            r_in <= i_item;
        end
        if (r_state == S_DONE && out_free) begin
            r_out <= r_res;
        end
    end

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_vld;
    assign o_result    = r_out;

    `CMT_CHECK(a_total_bound, (r_total >= CW'(1)) && (r_total <= MAX_CNT), "entry count out of range")
    `CMT_CHECK(a_eval_in_table, !r_ev_vld || (CW'(r_ev_idx) < r_total), "evaluated entry beyond table")
    `CMT_CHECK_NEXT(a_insert_grows, (r_state == S_SCAN) && finish && (n_res.outcome == MO_INSERTED) && (r_in.operation == OP_MERGE), r_total == $past(r_total) + 1'b1, "insert did not grow table")
endmodule
`default_nettype wire
